// ===== design/assert_macros.svh =====
// -----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the block checkers.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define FUT_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define FUT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define FUT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/fut_pkg.sv =====
// -----------------------------------------------------------------------------
// fut_pkg
// Constants and count codes of the first unique letter tracker.
// -----------------------------------------------------------------------------
package fut_pkg;

    localparam int LETTER_W          = 5;
    localparam int ALPHABET_SIZE_DEF = 26;
    localparam int COUNT_W           = 2;

    localparam logic [COUNT_W-1:0] CNT_ZERO = 2'd0;
    localparam logic [COUNT_W-1:0] CNT_ONCE = 2'd1;
    localparam logic [COUNT_W-1:0] CNT_MANY = 2'd2;

endpackage

// ===== design/fut_if.sv =====
// -----------------------------------------------------------------------------
// fut_if
// Valid/ready channels of the first unique letter tracker.
// -----------------------------------------------------------------------------
interface fut_in_if;
    import fut_pkg::*;

    logic                valid;
    logic                ready;
    logic [LETTER_W-1:0] letter;
    logic                start_of_string;

    modport source (output valid, output letter, output start_of_string, input ready);
    modport sink   (input valid, input letter, input start_of_string, output ready);
endinterface

interface fut_out_if;
    import fut_pkg::*;

    logic                valid;
    logic                ready;
    logic                found;
    logic [LETTER_W-1:0] first_unique;

    modport source (output valid, output found, output first_unique, input ready);
    modport sink   (input valid, input found, input first_unique, output ready);
endinterface

// ===== design/first_unique_letter_tracker_core.sv =====
// -----------------------------------------------------------------------------
// first_unique_letter_tracker_core
// Streaming first non-repeating letter: per-letter counts and first-seen order.
// -----------------------------------------------------------------------------
// Each request carries one letter and a start flag; each yields one result with
// the oldest letter seen exactly once in the current string. Counts live in a
// synchronous memory (registered read) with a valid flag per letter, so reset and
// the start flag clear them at once; the first-seen order lives in a second
// memory used as a circular queue. A request is accepted with its count read,
// then updated, when the queue head stays; when the head letter repeats, each
// following queue entry checked adds a queue read, a count read and a check.
// Each letter is dropped at most once per string. A result that is not taken
// holds the next completion until the output register frees.
module first_unique_letter_tracker_core #(
    parameter int ALPHABET_SIZE = fut_pkg::ALPHABET_SIZE_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    fut_in_if.sink   i_in,
    fut_out_if.source o_res
);
    import fut_pkg::*;

    localparam int IDX_W  = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
    localparam int FILL_W = $clog2(ALPHABET_SIZE + 1);
    localparam int CMP_W  = (LETTER_W > FILL_W) ? LETTER_W : FILL_W;
    localparam logic [IDX_W-1:0]  LAST_SLOT = IDX_W'(ALPHABET_SIZE - 1);
    localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(ALPHABET_SIZE);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_UPD   = 6'b000010,
        S_HREAD = 6'b000100,
        S_CREAD = 6'b001000,
        S_CHECK = 6'b010000,
        S_HOLD  = 6'b100000
    } t_state;

    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] s);
        return (s == LAST_SLOT) ? '0 : s + 1'b1;
    endfunction

    t_state r_state, n_state;
    logic [IDX_W-1:0]         r_head, n_head, r_tail, n_tail;
    logic [FILL_W-1:0]        r_fill, n_fill;
    logic [ALPHABET_SIZE-1:0] r_cvalid, n_cvalid;
    logic                     r_ovalid, n_ovalid;
    logic                     r_ofound, n_ofound;
    logic [LETTER_W-1:0]      r_oletter, n_oletter;
    logic                     r_pfound, n_pfound;
    logic [LETTER_W-1:0]      r_pletter, n_pletter;
    logic [LETTER_W-1:0]      r_sym, n_sym;
    logic                     r_in_range, n_in_range;
    logic [LETTER_W-1:0]      r_head_letter, n_head_letter;

    logic [COUNT_W-1:0]  m_count [ALPHABET_SIZE];
    logic [LETTER_W-1:0] m_fifo  [ALPHABET_SIZE];
    logic [COUNT_W-1:0]  r_count_q;
    logic [LETTER_W-1:0] r_fifo_q;

    logic                cnt_re, cnt_we, fifo_re, fifo_we;
    logic [IDX_W-1:0]    cnt_raddr, sym_idx, q_idx;
    logic [COUNT_W-1:0]  cnt_wdata, cnt_now;
    logic                fin, fin_found, out_free;
    logic [LETTER_W-1:0] fin_letter, cur_letter;
    logic                cur_found;

    assign sym_idx    = IDX_W'(r_sym);
    assign q_idx      = IDX_W'(r_fifo_q);
    assign cur_found  = (r_fill != '0);
    assign cur_letter = cur_found ? r_head_letter : '0;
    assign out_free   = !r_ovalid || o_res.ready;

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_res.valid        = r_ovalid;
    assign o_res.found        = r_ofound;
    assign o_res.first_unique = r_oletter;

    always_comb begin
        n_state       = r_state;
        n_head        = r_head;
        n_tail        = r_tail;
        n_fill        = r_fill;
        n_cvalid      = r_cvalid;
        n_sym         = r_sym;
        n_in_range    = r_in_range;
        n_head_letter = r_head_letter;
        n_pfound      = r_pfound;
        n_pletter     = r_pletter;
        cnt_re        = 1'b0;
        cnt_raddr     = sym_idx;
        cnt_we        = 1'b0;
        cnt_wdata     = CNT_ZERO;
        fifo_re       = 1'b0;
        fifo_we       = 1'b0;
        fin           = 1'b0;
        fin_found     = 1'b0;
        fin_letter    = '0;
        cnt_now       = CNT_ZERO;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_sym      = i_in.letter;
                    n_in_range = (CMP_W'(i_in.letter) < CMP_W'(ALPHABET_SIZE));
                    cnt_re     = n_in_range;
                    cnt_raddr  = IDX_W'(i_in.letter);
                    if (i_in.start_of_string) begin
                        n_cvalid = '0;
                        n_head   = '0;
                        n_tail   = '0;
                        n_fill   = '0;
                    end
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                cnt_now = r_cvalid[sym_idx] ? r_count_q : CNT_ZERO;
                if (!r_in_range) begin
                    fin        = 1'b1;
                    fin_found  = cur_found;
                    fin_letter = cur_letter;
                end else begin
                    cnt_we             = 1'b1;
                    n_cvalid[sym_idx]  = 1'b1;
                    if (cnt_now == CNT_ZERO) begin
                        cnt_wdata = CNT_ONCE;
                        if (r_fill != FULL_FILL) begin
                            fifo_we = 1'b1;
                            n_tail  = next_slot(r_tail);
                            n_fill  = r_fill + 1'b1;
                        end
                        fin = 1'b1;
                        if (r_fill == '0) begin
                            n_head_letter = r_sym;
                            fin_found     = 1'b1;
                            fin_letter    = r_sym;
                        end else begin
                            fin_found  = 1'b1;
                            fin_letter = r_head_letter;
                        end
                    end else begin
                        cnt_wdata = CNT_MANY;
                        if (cur_found && (r_head_letter == r_sym)) begin
                            n_head = next_slot(r_head);
                            n_fill = r_fill - 1'b1;
                            if (r_fill == FILL_W'(1)) begin
                                fin = 1'b1;
                            end else begin
                                n_state = S_HREAD;
                            end
                        end else begin
                            fin        = 1'b1;
                            fin_found  = cur_found;
                            fin_letter = cur_letter;
                        end
                    end
                end
            end
            S_HREAD: begin
                fifo_re = 1'b1;
                n_state = S_CREAD;
            end
            S_CREAD: begin
                cnt_re    = 1'b1;
                cnt_raddr = q_idx;
                n_state   = S_CHECK;
            end
            S_CHECK: begin
                cnt_now = r_cvalid[q_idx] ? r_count_q : CNT_ZERO;
                if (cnt_now > CNT_ONCE) begin
                    n_head = next_slot(r_head);
                    n_fill = r_fill - 1'b1;
                    if (r_fill == FILL_W'(1)) begin
                        fin = 1'b1;
                    end else begin
                        n_state = S_HREAD;
                    end
                end else begin
                    n_head_letter = r_fifo_q;
                    fin           = 1'b1;
                    fin_found     = 1'b1;
                    fin_letter    = r_fifo_q;
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (fin) begin
            if (out_free) begin
                n_state = S_IDLE;
            end else begin
                n_pfound  = fin_found;
                n_pletter = fin_letter;
                n_state   = S_HOLD;
            end
        end
    end

    always_comb begin
        n_ovalid  = r_ovalid && !o_res.ready;
        n_ofound  = r_ofound;
        n_oletter = r_oletter;
        if (fin && out_free) begin
            n_ovalid  = 1'b1;
            n_ofound  = fin_found;
            n_oletter = fin_letter;
        end else if ((r_state == S_HOLD) && out_free) begin
            n_ovalid  = 1'b1;
            n_ofound  = r_pfound;
            n_oletter = r_pletter;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_tail   <= '0;
            r_fill   <= '0;
            r_cvalid <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_fill   <= n_fill;
            r_cvalid <= n_cvalid;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sym         <= n_sym;
        r_in_range    <= n_in_range;
        r_head_letter <= n_head_letter;
        r_ofound      <= n_ofound;
        r_oletter     <= n_oletter;
        r_pfound      <= n_pfound;
        r_pletter     <= n_pletter;
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            m_count[sym_idx] <= cnt_wdata;
        end
        if (cnt_re) begin
            r_count_q <= m_count[cnt_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (fifo_we) begin
            m_fifo[r_tail] <= r_sym;
        end
        if (fifo_re) begin
            r_fifo_q <= m_fifo[r_head];
        end
    end

endmodule

// ===== design/fut_checker.sv =====
// -----------------------------------------------------------------------------
// fut_checker
// Port-level checks of the first unique letter tracker, bound to the core.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module fut_checker #(
    parameter int ALPHABET_SIZE = fut_pkg::ALPHABET_SIZE_DEF
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic                        i_found,
    input logic [fut_pkg::LETTER_W-1:0] i_first_unique
);
    import fut_pkg::*;

    `FUT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_found) && $stable(i_first_unique), "stalled result changed")
    `FUT_ASSERT_IMPL(a_none_zero, i_clk, i_rst_n, i_out_valid && !i_found, i_first_unique == '0, "letter nonzero without match")
    `FUT_ASSERT_IMPL(a_letter_range, i_clk, i_rst_n, i_out_valid && i_found, int'(i_first_unique) < ALPHABET_SIZE, "reported letter out of range")
    `FUT_ASSERT_NEXT(a_one_request, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "request taken while busy")

endmodule

bind first_unique_letter_tracker_core fut_checker #(
    .ALPHABET_SIZE(ALPHABET_SIZE)
) u_fut_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_found        (o_res.found),
    .i_first_unique (o_res.first_unique)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the first unique letter tracker.
// -----------------------------------------------------------------------------
// A short table of requests covers reset, extremes, the start flag, ignored
// letters, count saturation and an emptied queue. Random strings follow in
// three phases of differing source idling and sink stalls, each mixing alphabet
// permutations that fill the order queue and then repeat letters, short strings
// over random letter pools and noisy strings with stray start flags and ignored
// letters. Each accepted request runs through an internal copy of the tracker;
// its verdict, or the table's, is matched in order against each accepted result.
// -----------------------------------------------------------------------------
module tb_top;
    import fut_pkg::*;

    localparam int ALPHA     = ALPHABET_SIZE_DEF;
    localparam int PHASE_REQ = 376;

    typedef logic [LETTER_W-1:0] letter_t;

    typedef struct packed {
        logic    found;
        letter_t letter;
    } verdict_t;

    typedef struct packed {
        logic     start;
        letter_t  letter;
        logic     typed;
        verdict_t verdict;
    } table_row_t;

    localparam table_row_t DIRECTED_ROWS [22] = '{
        '{1'b0, 5'd25, 1'b1, '{1'b1, 5'd25}},
        '{1'b0, 5'd25, 1'b1, '{1'b0, 5'd0}},
        '{1'b0, 5'd31, 1'b1, '{1'b0, 5'd0}},
        '{1'b1, 5'd0,  1'b1, '{1'b1, 5'd0}},
        '{1'b0, 5'd16, 1'b0, '{1'b0, 5'd0}},
        '{1'b0, 5'd0,  1'b0, '{1'b0, 5'd0}},
        '{1'b0, 5'd0,  1'b0, '{1'b0, 5'd0}},
        '{1'b0, 5'd26, 1'b0, '{1'b0, 5'd0}},
        '{1'b0, 5'd16, 1'b0, '{1'b0, 5'd0}},
        '{1'b1, 5'd31, 1'b1, '{1'b0, 5'd0}},
        '{1'b0, 5'd3,  1'b1, '{1'b1, 5'd3}},
        '{1'b1, 5'd3,  1'b1, '{1'b1, 5'd3}},
        '{1'b0, 5'd7,  1'b0, '{1'b0, 5'd0}},
        '{1'b0, 5'd11, 1'b0, '{1'b0, 5'd0}},
        '{1'b0, 5'd3,  1'b0, '{1'b0, 5'd0}},
        '{1'b0, 5'd11, 1'b0, '{1'b0, 5'd0}},
        '{1'b0, 5'd7,  1'b0, '{1'b0, 5'd0}},
        '{1'b1, 5'd1,  1'b1, '{1'b1, 5'd1}},
        '{1'b0, 5'd30, 1'b0, '{1'b0, 5'd0}},
        '{1'b0, 5'd2,  1'b0, '{1'b0, 5'd0}},
        '{1'b0, 5'd1,  1'b0, '{1'b0, 5'd0}},
        '{1'b1, 5'd2,  1'b1, '{1'b1, 5'd2}}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    fut_in_if  req_if ();
    fut_out_if res_if ();

    first_unique_letter_tracker_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_res   (res_if)
    );

    logic [COUNT_W-1:0] letter_hits [ALPHA];
    letter_t            first_seen_order [$];
    verdict_t           pending_verdicts [$];
    int                 mismatch_count = 0;
    int                 letters_taken  = 0;
    int                 src_idle_pct   = 26;
    int                 sink_stall_pct = 88;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic verdict_t advance_tracker(input logic start, input letter_t letter);
        verdict_t v;
        if (start) begin
            foreach (letter_hits[i]) letter_hits[i] = CNT_ZERO;
            first_seen_order.delete();
        end
        if (letter < ALPHA) begin
            if (letter_hits[letter] == CNT_ZERO) begin
                first_seen_order.push_back(letter);
                letter_hits[letter] = CNT_ONCE;
            end else begin
                letter_hits[letter] = CNT_MANY;
            end
        end
        while (first_seen_order.size() > 0 && letter_hits[first_seen_order[0]] != CNT_ONCE)
            void'(first_seen_order.pop_front());
        v.found  = (first_seen_order.size() > 0);
        v.letter = v.found ? first_seen_order[0] : '0;
        return v;
    endfunction

    task automatic send_request(input logic start, input letter_t letter,
                                input logic typed, input verdict_t typed_verdict);
        verdict_t predicted;
        while ($urandom_range(99) < src_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid           <= 1'b1;
        req_if.letter          <= letter;
        req_if.start_of_string <= start;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        predicted = advance_tracker(start, letter);
        pending_verdicts.push_back(typed ? typed_verdict : predicted);
        if (letter < ALPHA) letters_taken++;
    endtask

    task automatic send_letter(input logic start, input letter_t letter);
        send_request(start, letter, 1'b0, '0);
    endtask

    // fill the queue with the whole alphabet, then repeat some of its letters
    task automatic send_permutation();
        letter_t perm [ALPHA];
        letter_t swap;
        int      j;
        int      mode;
        int      reps;
        foreach (perm[i]) perm[i] = letter_t'(i);
        for (int i = ALPHA - 1; i > 0; i--) begin
            j       = $urandom_range(i);
            swap    = perm[i];
            perm[i] = perm[j];
            perm[j] = swap;
        end
        foreach (perm[i]) send_letter(i == 0, perm[i]);
        mode = $urandom_range(2);
        reps = $urandom_range(1, ALPHA);
        for (int i = 0; i < reps; i++) begin
            case (mode)
                0: send_letter(1'b0, perm[ALPHA - 1 - i]);
                1: send_letter(1'b0, perm[i]);
                default: send_letter(1'b0, letter_t'($urandom_range(ALPHA - 1)));
            endcase
        end
    endtask

    task automatic send_string(input int len, input int pool, input int noise_pct);
        letter_t letter;
        logic    start;
        for (int i = 0; i < len; i++) begin
            letter = letter_t'($urandom_range(pool - 1));
            start  = (i == 0);
            if ($urandom_range(99) < noise_pct) letter = letter_t'($urandom_range(31));
            if ($urandom_range(99) < noise_pct / 3) start = 1'b1;
            send_letter(start, letter);
        end
    endtask

    task automatic run_phase(input int target);
        int kind;
        target += letters_taken;
        while (letters_taken < target) begin
            kind = $urandom_range(99);
            if (kind < 25)
                send_permutation();
            else if (kind < 75)
                send_string($urandom_range(1, 30), $urandom_range(1, ALPHA), 0);
            else
                send_string($urandom_range(1, 30), $urandom_range(1, ALPHA), 30);
        end
    endtask

    always @(posedge i_clk) begin
        verdict_t want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (pending_verdicts.size() == 0) begin
                    $display("%0t: result with no request pending: found=%0b letter=%0d",
                             $time, res_if.found, res_if.first_unique);
                    mismatch_count++;
                end else begin
                    want = pending_verdicts.pop_front();
                    if (res_if.found !== want.found) begin
                        $display("%0t: found mismatch: expected %0b, actual %0b",
                                 $time, want.found, res_if.found);
                        mismatch_count++;
                    end
                    if (res_if.first_unique !== want.letter) begin
                        $display("%0t: first_unique mismatch: expected %0d, actual %0d",
                                 $time, want.letter, res_if.first_unique);
                        mismatch_count++;
                    end
                end
            end
            res_if.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    initial begin
        foreach (letter_hits[i]) letter_hits[i] = CNT_ZERO;
        i_rst_n                <= 1'b0;
        req_if.valid           <= 1'b0;
        req_if.letter          <= '0;
        req_if.start_of_string <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED_ROWS[i])
            send_request(DIRECTED_ROWS[i].start, DIRECTED_ROWS[i].letter,
                         DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].verdict);
        run_phase(PHASE_REQ);

        src_idle_pct   = 88;
        sink_stall_pct = 26;
        run_phase(PHASE_REQ);

        src_idle_pct   = 0;
        sink_stall_pct = 0;
        run_phase(PHASE_REQ);

        req_if.valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #(10_000_000);
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/fut_pkg.sv
design/fut_if.sv
design/first_unique_letter_tracker_core.sv
design/fut_checker.sv
verif/tb_top.sv
